// ===== hw/rtl/fbsm_pkg.sv =====
`default_nettype none
package fbsm_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int FRAME_W   = 48;
   localparam int IDX_W     = 3;
   localparam int CNT_REG_W = 4;

   localparam logic [CNT_REG_W-1:0] CNT_RESET = 4'd8;

   typedef enum logic [1:0] {
      ACT_WR_CLAIM = 2'd0,
      ACT_PUBLISH  = 2'd1,
      ACT_RD_CLAIM = 2'd2,
      ACT_RELEASE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_WRITING = 2'd2,
      SLOT_READING = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NONE   = 2'd1,
      STAT_BADIDX = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_FETCH,
      ST_RESP
   } fsm_type;

endpackage
`default_nettype wire

// ===== hw/rtl/frame_buffer_slot_manager.sv =====
// Flow: a request is answered after a scan of n slots and an apply state (and a
// fetch state for a read claim that finds a slot), n being the managed slot count,
// min(count, SLOTS). The slot scan visits one slot per cycle through a single state
// compare, and the block is busy, taking no new request, until its response is taken.
// Reset: all slots free, all frame ids zero, slot count 8. No clearing pass.
`default_nettype none
module frame_buffer_slot_manager
   import fbsm_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_action,
   input  wire logic [IDX_W-1:0]     req_slot_index,
   input  wire logic [FRAME_W-1:0]   req_frame_number,
   input  wire logic                 req_allow_overwrite,
   input  wire logic                 req_flush_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [IDX_W-1:0]          rsp_granted_slot,
   output logic [FRAME_W-1:0]        rsp_granted_frame,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CNT_REG_W-1:0] csr_slots_in_use
);

   // the 4-bit count never reaches past slot 14, so only NMAX slots are kept
   localparam int NMAX  = (SLOTS < 15) ? SLOTS : 15;
   localparam int SW    = (NMAX > 1) ? $clog2(NMAX) : 1;
   localparam int CNT_W = $clog2(NMAX + 1);
   localparam int CW    = (SW > CNT_REG_W) ? SW : CNT_REG_W;

   fsm_type                  state_ff, state_in;
   action_type               act_ff, act_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [FRAME_W-1:0]       frame_ff, frame_in;
   logic                     ow_ff, ow_in;
   logic                     drop_ff, drop_in;
   logic                     idx_ok_ff, idx_ok_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [SW-1:0]            ptr_ff, ptr_in;
   logic                     free_hit_ff, free_hit_in;
   logic [SW-1:0]            free_k_ff, free_k_in;
   logic                     ready_hit_ff, ready_hit_in;
   logic [SW-1:0]            ready_k_ff, ready_k_in;
   status_type               status_ff, status_in;
   logic [IDX_W-1:0]         gslot_ff, gslot_in;
   logic [FRAME_W-1:0]       gframe_ff, gframe_in;
   logic [CNT_REG_W-1:0]     slots_ff;

   slot_state_type           slot_st_ff [NMAX];
   logic                     st_we;
   logic [SW-1:0]            st_waddr;
   slot_state_type           st_wdata;
   slot_state_type           cur_st;

   logic                     fs_we;
   logic                     fs_re;
   logic [SW-1:0]            fs_raddr;
   logic [FRAME_W-1:0]       fs_rdata;
   logic [CNT_W-1:0]         eff_cnt;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_status        = status_ff;
   assign rsp_granted_slot  = gslot_ff;
   assign rsp_granted_frame = gframe_ff;
   assign csr_ready         = 1'b1;

   assign eff_cnt = (slots_ff > CNT_REG_W'(NMAX)) ? CNT_W'(NMAX) : CNT_W'(slots_ff);
   assign cur_st  = slot_st_ff[ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         slots_ff <= csr_slots_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NMAX; i++) begin
            slot_st_ff[i] <= SLOT_FREE;
         end
      end else if (st_we) begin
         slot_st_ff[st_waddr] <= st_wdata;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      idx_ff       <= idx_in;
      frame_ff     <= frame_in;
      ow_ff        <= ow_in;
      drop_ff      <= drop_in;
      idx_ok_ff    <= idx_ok_in;
      n_ff         <= n_in;
      ptr_ff       <= ptr_in;
      free_hit_ff  <= free_hit_in;
      free_k_ff    <= free_k_in;
      ready_hit_ff <= ready_hit_in;
      ready_k_ff   <= ready_k_in;
      status_ff    <= status_in;
      gslot_ff     <= gslot_in;
      gframe_ff    <= gframe_in;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      frame_in     = frame_ff;
      ow_in        = ow_ff;
      drop_in      = drop_ff;
      idx_ok_in    = idx_ok_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      free_hit_in  = free_hit_ff;
      free_k_in    = free_k_ff;
      ready_hit_in = ready_hit_ff;
      ready_k_in   = ready_k_ff;
      status_in    = status_ff;
      gslot_in     = gslot_ff;
      gframe_in    = gframe_ff;
      st_we        = 1'b0;
      st_waddr     = ptr_ff;
      st_wdata     = SLOT_FREE;
      fs_we        = 1'b0;
      fs_re        = 1'b0;
      fs_raddr     = ready_k_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in       = action_type'(req_action);
               idx_in       = req_slot_index;
               frame_in     = req_frame_number;
               ow_in        = req_allow_overwrite;
               drop_in      = req_flush_ready;
               n_in         = eff_cnt;
               idx_ok_in    = CW'(req_slot_index) < CW'(eff_cnt);
               ptr_in       = '0;
               free_hit_in  = 1'b0;
               ready_hit_in = 1'b0;
               state_in     = (eff_cnt == '0) ? ST_APPLY : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // one slot per cycle; first hit of each kind is the lowest
            if (cur_st == SLOT_FREE && !free_hit_ff) begin
               free_hit_in = 1'b1;
               free_k_in   = ptr_ff;
            end
            if (cur_st == SLOT_READY && !ready_hit_ff) begin
               ready_hit_in = 1'b1;
               ready_k_in   = ptr_ff;
            end
            if (act_ff == ACT_PUBLISH && drop_ff && idx_ok_ff && cur_st == SLOT_READY &&
                CW'(ptr_ff) != CW'(idx_ff)) begin
               st_we    = 1'b1;
               st_waddr = ptr_ff;
               st_wdata = SLOT_FREE;
            end
            if (CW'(ptr_ff) == CW'(n_ff) - CW'(1)) begin
               state_in = ST_APPLY;
            end else begin
               ptr_in = ptr_ff + SW'(1);
            end
         end

         ST_APPLY: begin
            status_in = STAT_OK;
            gslot_in  = '0;
            gframe_in = '0;
            state_in  = ST_RESP;
            unique case (act_ff)
               ACT_WR_CLAIM: begin
                  if (free_hit_ff) begin
                     st_we    = 1'b1;
                     st_waddr = free_k_ff;
                     st_wdata = SLOT_WRITING;
                     gslot_in = IDX_W'(free_k_ff);
                  end else if (ow_ff && ready_hit_ff) begin
                     st_we    = 1'b1;
                     st_waddr = ready_k_ff;
                     st_wdata = SLOT_WRITING;
                     gslot_in = IDX_W'(ready_k_ff);
                  end else begin
                     status_in = STAT_NONE;
                  end
               end
               ACT_RD_CLAIM: begin
                  if (ready_hit_ff) begin
                     st_we    = 1'b1;
                     st_waddr = ready_k_ff;
                     st_wdata = SLOT_READING;
                     gslot_in = IDX_W'(ready_k_ff);
                     fs_re    = 1'b1;
                     state_in = ST_FETCH;
                  end else begin
                     status_in = STAT_NONE;
                  end
               end
               ACT_PUBLISH: begin
                  gslot_in = idx_ff;
                  if (idx_ok_ff) begin
                     st_we    = 1'b1;
                     st_waddr = SW'(idx_ff);
                     st_wdata = SLOT_READY;
                     fs_we    = 1'b1;
                  end else begin
                     status_in = STAT_BADIDX;
                  end
               end
               ACT_RELEASE: begin
                  gslot_in = idx_ff;
                  if (idx_ok_ff) begin
                     st_we    = 1'b1;
                     st_waddr = SW'(idx_ff);
                     st_wdata = SLOT_FREE;
                  end else begin
                     status_in = STAT_BADIDX;
                  end
               end
               default: status_in = STAT_NONE;
            endcase
         end

         ST_FETCH: begin
            gframe_in = fs_rdata;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   fbsm_frame_store #(
      .DEPTH (NMAX),
      .AW    (SW)
   ) u_frame_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fs_we),
      .wr_addr (SW'(idx_ff)),
      .wr_data (frame_ff),
      .rd_en   (fs_re),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/fbsm_frame_store.sv =====
`default_nettype none
module fbsm_frame_store
   import fbsm_pkg::*;
#(
   parameter int DEPTH = SLOTS_DEF,
   parameter int AW    = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [FRAME_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [FRAME_W-1:0] rd_data
);

   logic [FRAME_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [FRAME_W-1:0] rd_data_ff;
   logic               rd_vld_ff;

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/fbsm_checker.sv =====
`default_nettype none
module fbsm_checker
   import fbsm_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_status,
   input wire logic [IDX_W-1:0]   rsp_granted_slot,
   input wire logic [FRAME_W-1:0] rsp_granted_frame
);

   // a held item keeps its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_granted_slot) && $stable(rsp_granted_frame))
      else $error("rsp item changed while stalled");

   // one item at a time: no new request while a result is pending
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while result pending");

   // a request is not answered before the apply state has run
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result too early after request");

   // failed requests carry no frame id
   a_fail_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NONE || rsp_status == STAT_BADIDX) |->
         rsp_granted_frame == '0)
      else $error("frame id on failed request");

   // a claim that finds nothing reports slot zero
   a_none_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NONE |-> rsp_granted_slot == '0)
      else $error("nonzero slot on empty claim");

endmodule

bind frame_buffer_slot_manager fbsm_checker u_fbsm_checker (.*);
`default_nettype wire
